>>> rtl/srb_pkg.sv
// Shared types and constants for the sequence reorder buffer.
`default_nettype none
package srb_pkg;

  localparam logic [23:0] TIMEOUT_RESET = 24'd1000;
  localparam logic [23:0] AGE_MAX       = 24'hFFFFFF;

  localparam logic KIND_DATAGRAM = 1'b0;
  localparam logic KIND_TICK     = 1'b1;
  localparam logic RES_DELIVER   = 1'b0;
  localparam logic RES_SKIP      = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [15:0] seq_number;
    logic [31:0] payload_handle;
  } in_t;

  typedef struct packed {
    logic        result_kind;
    logic [15:0] delivered_seq;
    logic [31:0] delivered_handle;
    logic [5:0]  skipped_count;
    logic [15:0] ack_number;
    logic        ack_valid;
    logic        last;
  } out_t;

endpackage
`default_nettype wire

>>> rtl/sequence_reorder_buffer_gap_skip.sv
// Top level of the sequence reorder buffer with gap skipping.
`default_nettype none
// Restores datagram order over 16-bit wrapping sequence numbers. A beat is
// taken when start is high and busy is low; busy then stays high until every
// result of that beat has been shown. Results come one at a time on out_data,
// each marked by out_valid for exactly one cycle, and cannot be stalled; the
// final result of a beat has out_data.last set. One read port of the slot
// memory is walked by a small sequencer: an in-order datagram rescans the
// slots after each delivered result until a scan misses, a held datagram
// scans for a copy and a free slot, a timeout skip finds the nearest held
// number and counts the skip by repeated subtraction, a late, far or first
// datagram needs no scan, and a non-skipping tick never raises busy, so the
// next beat may follow at once. The user must have gap_timeout_ticks written
// through cfg_wr_en / cfg_wr_data only while idle; the block does not check.
module sequence_reorder_buffer_gap_skip #(
  parameter int WINDOW   = 32,
  parameter int SEQ_STEP = 1
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              start,
  output logic             busy,
  input  srb_pkg::in_t     in_data,
  output logic             out_valid,
  output srb_pkg::out_t    out_data,
  input  wire              cfg_wr_en,
  input  wire [23:0]       cfg_wr_data
);

  localparam int IW = $clog2(WINDOW);
  localparam int CW = $clog2(WINDOW + 1);
  localparam logic [15:0] STEP16 = 16'(SEQ_STEP);
  localparam logic [15:0] WIN16  = 16'(WINDOW);
  localparam logic [IW-1:0] LAST_IDX = IW'(WINDOW - 1);

  typedef enum logic [2:0] {S_IDLE, S_RD, S_CK, S_DIV, S_DEND, S_DONE} state_t;
  typedef enum logic [1:0] {M_INS, M_DRAIN, M_MIN} mode_t;

  state_t              state_r, state_nxt;
  mode_t               mode_r, mode_nxt;
  logic [23:0]         tmo_r, tmo_nxt;
  logic [15:0]         exp_r, exp_nxt;
  logic                known_r, known_nxt;
  logic                gap_r, gap_nxt;
  logic [23:0]         age_r, age_nxt;
  logic [WINDOW-1:0]   valid_r, valid_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;
  logic [IW-1:0]       free_r, free_nxt;
  logic                free_v_r, free_v_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [CW-1:0]       near_r, near_nxt;
  logic [CW-1:0]       quo_r, quo_nxt;
  logic [15:0]         it_seq_r, it_seq_nxt;
  logic [31:0]         it_hdl_r, it_hdl_nxt;
  srb_pkg::out_t       pend_r, pend_nxt;
  logic                pend_v_r, pend_v_nxt;
  srb_pkg::out_t       out_r, out_nxt;
  logic                out_v_r, out_v_nxt;

  // slot memory: one write and one registered read port
  logic [15:0]         mem_seq [WINDOW];
  logic [31:0]         mem_hdl [WINDOW];
  logic [15:0]         rd_seq_r;
  logic [31:0]         rd_hdl_r;
  logic                mem_we;

  logic                emit_v;
  logic                emit_kind;
  logic [15:0]         emit_seq;
  logic [31:0]         emit_hdl;
  logic [5:0]          emit_skip;
  logic [15:0]         ahead, behind, lead;
  logic [23:0]         age_inc;
  logic                slot_v;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_seq[free_r] <= it_seq_r;
      mem_hdl[free_r] <= it_hdl_r;
    end
    rd_seq_r <= mem_seq[idx_r];
    rd_hdl_r <= mem_hdl[idx_r];
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  assign ahead   = in_data.seq_number - exp_r;
  assign behind  = exp_r - in_data.seq_number;
  assign lead    = rd_seq_r - exp_r;
  assign age_inc = (age_r == srb_pkg::AGE_MAX) ? age_r : age_r + 24'd1;
  assign slot_v  = valid_r[idx_r];

  always_comb begin
    state_nxt  = state_r;
    mode_nxt   = mode_r;
    tmo_nxt    = cfg_wr_en ? cfg_wr_data : tmo_r;
    exp_nxt    = exp_r;
    known_nxt  = known_r;
    gap_nxt    = gap_r;
    age_nxt    = age_r;
    valid_nxt  = valid_r;
    idx_nxt    = idx_r;
    free_nxt   = free_r;
    free_v_nxt = free_v_r;
    cnt_nxt    = cnt_r;
    near_nxt   = near_r;
    quo_nxt    = quo_r;
    it_seq_nxt = it_seq_r;
    it_hdl_nxt = it_hdl_r;
    emit_v     = 1'b0;
    emit_kind  = srb_pkg::RES_DELIVER;
    emit_seq   = '0;
    emit_hdl   = '0;
    emit_skip  = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          it_seq_nxt = in_data.seq_number;
          it_hdl_nxt = in_data.payload_handle;
          cnt_nxt    = '0;
          idx_nxt    = '0;
          if (in_data.kind == srb_pkg::KIND_DATAGRAM) begin
            if (known_r && ahead == 16'd0) begin
              // in order: deliver, then drain held successors
              exp_nxt   = in_data.seq_number + STEP16;
              emit_v    = 1'b1;
              emit_seq  = in_data.seq_number;
              emit_hdl  = in_data.payload_handle;
              cnt_nxt   = CW'(1);
              mode_nxt  = M_DRAIN;
              state_nxt = S_RD;
            end else if (known_r && ahead < WIN16) begin
              free_v_nxt = 1'b0;
              mode_nxt   = M_INS;
              state_nxt  = S_RD;
            end else if (known_r && behind <= WIN16) begin
              state_nxt = S_DONE;
            end else begin
              // first datagram or far jump: restart from this one
              valid_nxt = '0;
              gap_nxt   = 1'b0;
              age_nxt   = '0;
              known_nxt = 1'b1;
              exp_nxt   = in_data.seq_number + STEP16;
              emit_v    = 1'b1;
              emit_seq  = in_data.seq_number;
              emit_hdl  = in_data.payload_handle;
              state_nxt = S_DONE;
            end
          end else if (gap_r) begin
            age_nxt = age_inc;
            if ((|valid_r) && age_inc >= tmo_r) begin
              near_nxt  = CW'(WINDOW);
              mode_nxt  = M_MIN;
              state_nxt = S_RD;
            end
          end
        end
      end
      S_RD: begin
        state_nxt = S_CK;
      end
      S_CK: begin
        state_nxt = S_RD;
        idx_nxt   = idx_r + IW'(1);
        case (mode_r)
          M_INS: begin
            if (slot_v && rd_seq_r == it_seq_r) begin
              state_nxt = S_DONE;
            end else begin
              if (!slot_v && !free_v_r) begin
                free_v_nxt = 1'b1;
                free_nxt   = idx_r;
              end
              if (idx_r == LAST_IDX) begin
                state_nxt = S_DONE;
              end
            end
          end
          M_DRAIN: begin
            if (slot_v && rd_seq_r == exp_r) begin
              valid_nxt[idx_r] = 1'b0;
              exp_nxt  = exp_r + STEP16;
              emit_v   = 1'b1;
              emit_seq = rd_seq_r;
              emit_hdl = rd_hdl_r;
              cnt_nxt  = cnt_r + CW'(1);
              idx_nxt  = '0;
              if (cnt_r + CW'(1) >= CW'(WINDOW)) begin
                state_nxt = S_DEND;
              end
            end else if (idx_r == LAST_IDX) begin
              state_nxt = S_DEND;
            end
          end
          M_MIN: begin
            if (slot_v && lead < {{(16-CW){1'b0}}, near_r}) begin
              near_nxt = lead[CW-1:0];
            end
            if (idx_r == LAST_IDX) begin
              quo_nxt   = '0;
              state_nxt = S_DIV;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_DIV: begin
        // skip count by repeated subtraction of the step
        if ({{(16-CW){1'b0}}, near_r} >= STEP16) begin
          near_nxt = CW'({{(16-CW){1'b0}}, near_r} - STEP16);
          quo_nxt  = quo_r + CW'(1);
        end else begin
          exp_nxt   = exp_r + 16'(quo_r) * STEP16 + 16'(near_r);
          emit_v    = 1'b1;
          emit_kind = srb_pkg::RES_SKIP;
          emit_skip = 6'(quo_r);
          cnt_nxt   = cnt_r + CW'(1);
          idx_nxt   = '0;
          mode_nxt  = M_DRAIN;
          state_nxt = S_RD;
        end
      end
      S_DEND: begin
        gap_nxt   = |valid_r;
        age_nxt   = '0;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    // commit a held datagram once the whole slot scan found no copy
    if (state_r == S_CK && mode_r == M_INS && state_nxt == S_DONE && idx_r == LAST_IDX &&
        !(slot_v && rd_seq_r == it_seq_r) && free_v_nxt) begin
      free_nxt             = free_v_r ? free_r : idx_r;
      valid_nxt[free_nxt]  = 1'b1;
      if (!gap_r) begin
        gap_nxt = 1'b1;
        age_nxt = '0;
      end
    end
  end

  // write port follows the committed insert in the next cycle, through ins_pend_r
  logic ins_pend_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ins_pend_r <= 1'b0;
    end else begin
      ins_pend_r <= (state_r == S_CK && mode_r == M_INS && state_nxt == S_DONE &&
                     idx_r == LAST_IDX && !(slot_v && rd_seq_r == it_seq_r) && free_v_nxt);
    end
  end
  assign mem_we = ins_pend_r;

  // emit path: hold one result back so the final one can carry last
  always_comb begin
    pend_nxt   = pend_r;
    pend_v_nxt = pend_v_r;
    out_nxt    = out_r;
    out_v_nxt  = 1'b0;
    if (emit_v) begin
      if (pend_v_r) begin
        out_nxt   = pend_r;
        out_v_nxt = 1'b1;
      end
      pend_nxt.result_kind      = emit_kind;
      pend_nxt.delivered_seq    = emit_seq;
      pend_nxt.delivered_handle = emit_hdl;
      pend_nxt.skipped_count    = emit_skip;
      pend_nxt.ack_number       = exp_nxt - STEP16;
      pend_nxt.ack_valid        = 1'b1;
      pend_nxt.last             = 1'b0;
      pend_v_nxt                = 1'b1;
    end else if (state_r == S_DONE && pend_v_r) begin
      out_nxt      = pend_r;
      out_nxt.last = 1'b1;
      out_v_nxt    = 1'b1;
      pend_v_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      mode_r   <= M_INS;
      tmo_r    <= srb_pkg::TIMEOUT_RESET;
      exp_r    <= '0;
      known_r  <= 1'b0;
      gap_r    <= 1'b0;
      age_r    <= '0;
      valid_r  <= '0;
      idx_r    <= '0;
      free_v_r <= 1'b0;
      cnt_r    <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      mode_r   <= mode_nxt;
      tmo_r    <= tmo_nxt;
      exp_r    <= exp_nxt;
      known_r  <= known_nxt;
      gap_r    <= gap_nxt;
      age_r    <= age_nxt;
      valid_r  <= valid_nxt;
      idx_r    <= idx_nxt;
      free_v_r <= free_v_nxt;
      cnt_r    <= cnt_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
    free_r   <= free_nxt;
    near_r   <= near_nxt;
    quo_r    <= quo_nxt;
    it_seq_r <= it_seq_nxt;
    it_hdl_r <= it_hdl_nxt;
    pend_r   <= pend_nxt;
    out_r    <= out_nxt;
  end

  a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.result_kind == srb_pkg::RES_SKIP |->
      out_r.delivered_seq == 16'd0 && out_r.delivered_handle == 32'd0)
    else $error("skip notice carries datagram fields");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(WINDOW))
    else $error("result count exceeds window");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !pend_v_r)
    else $error("result left pending while idle");

  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_r.last |=> !out_v_r)
    else $error("result follows last of a beat");

endmodule
`default_nettype wire

>>> dv/tb_sequence_reorder_buffer_gap_skip.sv
// Testbench for the sequence reorder buffer with gap skipping.
`timescale 1ns / 1ps
module tb_sequence_reorder_buffer_gap_skip;

  localparam int WINDOW   = 32;
  localparam int SEQ_STEP = 1;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 600;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  srb_pkg::in_t  in_data;
  logic out_valid;
  srb_pkg::out_t out_data;
  logic cfg_wr_en;
  logic [23:0] cfg_wr_data;

  sequence_reorder_buffer_gap_skip #(.WINDOW(WINDOW), .SEQ_STEP(SEQ_STEP)) i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // Predictor state: our own copy of the reorder buffer.
  logic [23:0] timeout_ticks;
  logic [15:0] next_seq;
  logic        next_known;
  logic        gap_is_open;
  logic [23:0] gap_ticks;
  logic        held_valid [WINDOW];
  logic [15:0] held_seq   [WINDOW];
  logic [31:0] held_handle[WINDOW];

  srb_pkg::out_t pending_results[$];
  srb_pkg::in_t  beat_queue[$];
  int    errors;
  int    beats_sent;
  int    results_seen;
  int    skips_seen;
  int    idle_cycles;
  logic  beat_taken;

  function automatic void wipe_buffer();
    next_seq = '0;
    next_known = 1'b0;
    gap_is_open = 1'b0;
    gap_ticks = '0;
    for (int i = 0; i < WINDOW; i++) held_valid[i] = 1'b0;
  endfunction

  function automatic int held_slot(logic [15:0] s);
    for (int i = 0; i < WINDOW; i++)
      if (held_valid[i] && held_seq[i] == s) return i;
    return -1;
  endfunction

  function automatic logic any_slot_held();
    for (int i = 0; i < WINDOW; i++)
      if (held_valid[i]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void push_result(logic k, logic [15:0] s, logic [31:0] h,
                                      logic [5:0] cnt, ref srb_pkg::out_t beat_res[$]);
    srb_pkg::out_t r;
    r.result_kind      = k;
    r.delivered_seq    = s;
    r.delivered_handle = h;
    r.skipped_count    = cnt;
    r.ack_number       = next_seq - 16'(SEQ_STEP);
    r.ack_valid        = next_known;
    r.last             = 1'b0;
    beat_res.push_back(r);
  endfunction

  // Deliver held successors in order, then reopen the gap if anything is left.
  function automatic void drain_held(ref srb_pkg::out_t beat_res[$]);
    int s;
    logic [15:0] q;
    logic [31:0] h;
    s = held_slot(next_seq);
    while (s >= 0 && beat_res.size() < WINDOW) begin
      q = held_seq[s];
      h = held_handle[s];
      held_valid[s] = 1'b0;
      next_seq = next_seq + 16'(SEQ_STEP);
      push_result(srb_pkg::RES_DELIVER, q, h, '0, beat_res);
      s = held_slot(next_seq);
    end
    gap_is_open = any_slot_held();
    gap_ticks = '0;
  endfunction

  // Work out every result one accepted beat causes and queue them.
  function automatic void predict_order(srb_pkg::in_t b);
    srb_pkg::out_t beat_res[$];
    logic [15:0] ahead, behind, nearest, d;
    if (b.kind == srb_pkg::KIND_DATAGRAM) begin
      if (next_known) begin
        ahead  = b.seq_number - next_seq;
        behind = next_seq - b.seq_number;
        if (ahead == 0) begin
          next_seq = b.seq_number + 16'(SEQ_STEP);
          push_result(srb_pkg::RES_DELIVER, b.seq_number, b.payload_handle, '0, beat_res);
          drain_held(beat_res);
        end else if (ahead < WINDOW) begin
          if (held_slot(b.seq_number) < 0) begin
            for (int i = 0; i < WINDOW; i++) begin
              if (!held_valid[i]) begin
                held_valid[i]  = 1'b1;
                held_seq[i]    = b.seq_number;
                held_handle[i] = b.payload_handle;
                if (!gap_is_open) begin
                  gap_is_open = 1'b1;
                  gap_ticks = '0;
                end
                break;
              end
            end
          end
        end else if (behind <= WINDOW) begin
          // late datagram: drop
        end else begin
          wipe_buffer();
        end
      end
      if (!next_known) begin
        next_known = 1'b1;
        next_seq = b.seq_number + 16'(SEQ_STEP);
        push_result(srb_pkg::RES_DELIVER, b.seq_number, b.payload_handle, '0, beat_res);
      end
    end else if (gap_is_open) begin
      if (gap_ticks != srb_pkg::AGE_MAX) gap_ticks = gap_ticks + 1'b1;
      if (any_slot_held() && gap_ticks >= timeout_ticks) begin
        nearest = 16'(WINDOW);
        for (int i = 0; i < WINDOW; i++) begin
          if (held_valid[i]) begin
            d = held_seq[i] - next_seq;
            if (d < nearest) nearest = d;
          end
        end
        next_seq = next_seq + nearest;
        push_result(srb_pkg::RES_SKIP, '0, '0, 6'(nearest / SEQ_STEP), beat_res);
        drain_held(beat_res);
      end
    end
    if (beat_res.size() > 0) beat_res[beat_res.size() - 1].last = 1'b1;
    foreach (beat_res[i]) pending_results.push_back(beat_res[i]);
  endfunction

  // Driver: bursts of back-to-back beats separated by random gaps.
  int burst_left;
  int gap_left;
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else if (start) begin
      // Hold the beat until it is taken; then pick the next one without a low pulse.
      if (beat_taken) begin
        if (burst_left > 0 && beat_queue.size() > 0) begin
          in_data <= beat_queue.pop_front();
          burst_left--;
        end else begin
          start <= 1'b0;
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end else if (beat_queue.size() > 0) begin
      if (gap_left > 0) gap_left--;
      else begin
        in_data <= beat_queue.pop_front();
        start <= 1'b1;
        burst_left = $urandom_range(0, 8);
      end
    end
  end

  // Monitor: predict on acceptance, check each result strobe.
  srb_pkg::out_t want;
  always @(posedge clk) begin
    if (rst_n) begin
      beat_taken <= start && !busy;
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (start && !busy) begin
        predict_order(in_data);
        beats_sent <= beats_sent + 1;
      end
      if (out_valid) begin
        results_seen <= results_seen + 1;
        if (out_data.result_kind == srb_pkg::RES_SKIP) skips_seen <= skips_seen + 1;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
          errors <= errors + 1;
        end else begin
          want = pending_results.pop_front();
          if (out_data !== want) begin
            $display("%0t: result mismatch, expected %p, actual %p", $time, want, out_data);
            errors <= errors + 1;
          end
        end
      end
    end
  end

  // Watchdog: stop if nothing moves for too long.
  always @(posedge clk) begin
    if (rst_n && idle_cycles > WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic srb_pkg::in_t make_beat(logic k, logic [15:0] s, logic [31:0] h);
    srb_pkg::in_t b;
    b.kind = k;
    b.seq_number = s;
    b.payload_handle = h;
    return b;
  endfunction

  function automatic void queue_tick();
    beat_queue.push_back(make_beat(srb_pkg::KIND_TICK, 16'($urandom), $urandom));
  endfunction

  function automatic void queue_datagram(logic [15:0] s);
    beat_queue.push_back(make_beat(srb_pkg::KIND_DATAGRAM, s, $urandom));
  endfunction

  // Wait until every queued beat is taken and every result has come out.
  task automatic settle();
    while (beat_queue.size() > 0 || start || pending_results.size() > 0 || busy)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_timeout(logic [23:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    timeout_ticks = v;
  endtask

  // A window of shuffled, gapped and duplicated datagrams with ticks mixed in.
  task automatic queue_window(ref logic [15:0] base, input int ticks_max);
    logic [15:0] order[$];
    int n;
    int j;
    logic [15:0] t;
    n = $urandom_range(2, 12);
    for (int i = 0; i < n; i++)
      if ($urandom_range(0, 5) != 0) order.push_back(base + 16'(i));
    for (int i = order.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i]; order[i] = order[j]; order[j] = t;
    end
    foreach (order[i]) begin
      queue_datagram(order[i]);
      if ($urandom_range(0, 6) == 0) queue_datagram(order[i]);
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, ticks_max)) queue_tick();
    end
    repeat ($urandom_range(0, ticks_max)) queue_tick();
    base = base + 16'(n);
  endtask

  logic [15:0] stream_pos;
  int phase_items;
  initial begin
    start = 1'b0;
    rst_n = 1'b0;
    in_data = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    errors = 0;
    beats_sent = 0;
    results_seen = 0;
    skips_seen = 0;
    idle_cycles = 0;
    beat_taken = 1'b0;
    timeout_ticks = srb_pkg::TIMEOUT_RESET;
    wipe_buffer();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: first datagram, in order, hold, duplicates, far jump, wrap.
    queue_tick();
    queue_datagram(16'hFFFE);
    queue_datagram(16'hFFFF);
    queue_datagram(16'h0001);
    queue_datagram(16'h0001);
    queue_datagram(16'h001E);
    queue_datagram(16'h001F);
    queue_datagram(16'h0000);
    queue_datagram(16'h0000);
    queue_datagram(16'hFFE2);
    queue_datagram(16'hFFE1);
    queue_datagram(16'h8000);
    beat_queue.push_back(make_beat(srb_pkg::KIND_DATAGRAM, 16'h8001, 32'hFFFF_FFFF));
    beat_queue.push_back(make_beat(srb_pkg::KIND_DATAGRAM, 16'h8002, 32'h0000_0000));
    settle();

    // Zero timeout: the first tick of a gap skips to the nearest held number.
    write_timeout(24'd0);
    queue_datagram(16'h8005);
    queue_datagram(16'h8021);
    queue_tick();
    queue_datagram(16'h8021);
    queue_tick();
    queue_tick();
    settle();

    // Largest timeout: the gap does not age out over these ticks; a far jump clears it.
    write_timeout(24'hFFFFFF);
    queue_datagram(16'h8030);
    repeat (4) queue_tick();
    queue_datagram(16'h1234);
    settle();

    // Random phases over several timeout settings.
    stream_pos = 16'($urandom);
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_timeout(24'd1);
        1: write_timeout(24'($urandom_range(2, 5)));
        2: write_timeout(24'd0);
        3: write_timeout(24'($urandom));
        default: write_timeout(24'd3);
      endcase
      phase_items = 0;
      while (phase_items < 45) begin
        int before_sz;
        before_sz = beat_queue.size();
        if ($urandom_range(0, 9) == 0) queue_datagram(16'($urandom));
        else if ($urandom_range(0, 9) == 0) queue_datagram(stream_pos - 16'($urandom_range(1, 40)));
        else queue_window(stream_pos, 4);
        phase_items += beat_queue.size() - before_sz;
      end
      settle();
    end

    $display("covered %0d beats, %0d results checked, %0d skip notices", beats_sent,
             results_seen, skips_seen);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results never seen", errors, pending_results.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> sequence_reorder_buffer_gap_skip.f
rtl/srb_pkg.sv
rtl/sequence_reorder_buffer_gap_skip.sv
dv/tb_sequence_reorder_buffer_gap_skip.sv
